// ===== rtl/core/sync_length_xor_frame_receiver_core_assert.svh =====
// Assertion macros for the frame receiver RTL.
// Needs nothing else; sxfr_back includes it by bare file name.
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SXFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sxfr: same-cycle check failed");

// next-cycle implication, disabled in reset
`define SXFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sxfr: next-cycle check failed");

`endif

// ===== rtl/core/sxfr_pkg.sv =====
// Shared types and constants for the sync/length/XOR frame receiver.
// No dependencies.
package sxfr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 32;
  localparam logic [7:0] SYNC_BYTE_RST = 8'hAA;

  // command address is wide enough for the largest supported payload (64)
  localparam int ADDR_W = 6;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // front-to-back command codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REPLAY = 2'd1;
  localparam logic [1:0] OP_ERROR  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;   // payload byte, or computed XOR for OP_ERROR
  } cmd_t;

  typedef struct packed {
    logic       frame_status;
    logic [7:0] out_byte;
    logic       is_last;
  } res_t;

endpackage

// ===== rtl/core/sxfr_front.sv =====
// Front end: sync hunt, payload count and running XOR; emits back-end commands.
// Depends on sxfr_pkg.
module sxfr_front #(
  parameter int PAYLOAD_BYTES = sxfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sync_byte_we,
  input  logic [7:0]        sync_byte_wdata,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte,
  input  logic              abort,
  output logic              cmd_push,
  output sxfr_pkg::cmd_t    cmd,
  input  logic              cmd_full
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  logic [7:0]    sync_byte;
  logic [1:0]    phase, phase_next;
  logic [AW-1:0] count, count_next;
  logic [7:0]    run_xor, run_xor_next;
  logic          accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= sxfr_pkg::SYNC_BYTE_RST;
    end else if (sync_byte_we) begin
      sync_byte <= sync_byte_wdata;
    end
  end

  always_comb begin
    phase_next   = phase;
    count_next   = count;
    run_xor_next = run_xor;
    cmd_push     = 1'b0;
    cmd.op       = sxfr_pkg::OP_WRITE;
    cmd.addr     = sxfr_pkg::ADDR_W'(count);
    cmd.data     = rx_byte;
    if (accept) begin
      if (abort) begin
        phase_next   = PH_HUNT;
        count_next   = '0;
        run_xor_next = '0;
      end else begin
        unique case (phase)
          PH_DATA: begin
            cmd_push     = 1'b1;
            run_xor_next = run_xor ^ rx_byte;
            if (count == AW'(PAYLOAD_BYTES - 1)) begin
              count_next = '0;
              phase_next = PH_CHECK;
            end else begin
              count_next = count + 1'b1;
            end
          end
          PH_CHECK: begin
            cmd_push     = 1'b1;
            cmd.op       = (rx_byte == run_xor) ? sxfr_pkg::OP_REPLAY : sxfr_pkg::OP_ERROR;
            cmd.data     = run_xor;
            phase_next   = PH_HUNT;
            count_next   = '0;
            run_xor_next = '0;
          end
          default: begin
            // unused code behaves as hunting
            count_next   = '0;
            run_xor_next = '0;
            phase_next   = (rx_byte == sync_byte) ? PH_DATA : PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      count   <= '0;
      run_xor <= '0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      run_xor <= run_xor_next;
    end
  end

endmodule

// ===== rtl/core/sxfr_cmdq.sv =====
// Small command FIFO between front and back ends.
// Depends on sxfr_pkg.
module sxfr_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sxfr_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sxfr_pkg::cmd_t rdata
);

  localparam int DEPTH = sxfr_pkg::CMDQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  sxfr_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sxfr_back.sv =====
// Back end: payload store, replay sequencer and result FIFO.
// Depends on sxfr_pkg and the assertion macro header.
`include "sync_length_xor_frame_receiver_core_assert.svh"
module sxfr_back #(
  parameter int PAYLOAD_BYTES = sxfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  sxfr_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output sxfr_pkg::res_t res
);

  localparam int AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int DEPTH = sxfr_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // payload store
  logic [7:0]    mem [PAYLOAD_BYTES];
  logic [7:0]    rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  // replay sequencer
  logic          busy, busy_next;
  logic [AW-1:0] idx, idx_next;
  logic          issue;
  logic          issue_mem;
  logic          issue_last;
  logic [7:0]    issue_xor;
  logic          space;

  // read stage
  logic          s1_valid;
  logic          s1_from_mem;
  logic          s1_last;
  logic [7:0]    s1_xor;

  // result FIFO
  sxfr_pkg::res_t outq [DEPTH];
  sxfr_pkg::res_t push_res;
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  ocnt;
  logic           do_pop;

  // room for the in-flight read plus one more
  assign space = ((CW + 1)'(ocnt) + (CW + 1)'(s1_valid)) < (CW + 1)'(DEPTH);

  always_comb begin
    busy_next  = busy;
    idx_next   = idx;
    issue      = 1'b0;
    issue_mem  = 1'b1;
    issue_last = (idx == AW'(PAYLOAD_BYTES - 1));
    issue_xor  = cmd.data;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cmd.addr[AW-1:0];
    if (busy) begin
      if (space) begin
        issue = 1'b1;
        if (issue_last) begin
          busy_next = 1'b0;
          idx_next  = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
    end else if (!cmd_empty) begin
      unique case (cmd.op)
        sxfr_pkg::OP_WRITE: begin
          mem_we  = 1'b1;
          cmd_pop = 1'b1;
        end
        sxfr_pkg::OP_REPLAY: begin
          cmd_pop   = 1'b1;
          busy_next = 1'b1;
          idx_next  = '0;
        end
        sxfr_pkg::OP_ERROR: begin
          if (space) begin
            issue      = 1'b1;
            issue_mem  = 1'b0;
            issue_last = 1'b1;
            cmd_pop    = 1'b1;
          end
        end
        default: begin
          cmd_pop = 1'b1;  // no such command is ever produced
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && issue_mem) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_from_mem <= issue_mem;
      s1_last     <= issue_last;
      s1_xor      <= issue_xor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      s1_valid <= 1'b0;
    end else begin
      busy     <= busy_next;
      idx      <= idx_next;
      s1_valid <= issue;
    end
  end

  assign push_res.frame_status = !s1_from_mem;
  assign push_res.out_byte     = s1_from_mem ? rd_q : s1_xor;
  assign push_res.is_last      = s1_last;

  assign empty  = (ocnt == '0);
  assign do_pop = pop && !empty;
  assign res    = outq[rd_ptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      outq[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      ocnt   <= '0;
    end else begin
      if (s1_valid) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)   rd_ptr <= rd_ptr + 1'b1;
      if (s1_valid && !do_pop) begin
        ocnt <= ocnt + 1'b1;
      end else if (do_pop && !s1_valid) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

  // read stage never lands on a full result FIFO
  `SXFR_ASSERT_NOW(a_no_outq_overflow, clk, rst, s1_valid, ocnt < CW'(DEPTH))
  // commands wait while a replay runs
  `SXFR_ASSERT_NOW(a_no_cmd_during_replay, clk, rst, busy, !cmd_pop)
  // the last replay read ends the replay
  `SXFR_ASSERT_NEXT(a_replay_ends, clk, rst, busy && issue && issue_last, !busy)
  // error report is a single-entry run
  `SXFR_ASSERT_NOW(a_error_is_last, clk, rst, s1_valid && !s1_from_mem, s1_last)

endmodule

// ===== rtl/core/sync_length_xor_frame_receiver_core.sv =====
// Path: a good checksum byte's first result reaches the ports through the command queue,
// replay start, store read and result FIFO write; a mismatch report skips replay start.
// Throughput: one byte per cycle accepted while the 4-entry command queue has room;
// a good frame replays PAYLOAD_BYTES results at one per cycle while outq has room.
// Reset (rst, synchronous): hunting, queues empty, sync byte 0xAA; store undefined.
module sync_length_xor_frame_receiver_core #(
  parameter int PAYLOAD_BYTES = sxfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sync_byte_we,
  input  logic [7:0] sync_byte_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       abort,
  output logic       empty,
  input  logic       pop,
  output logic       frame_status,
  output logic [7:0] out_byte,
  output logic       is_last
);

  logic           q_push, q_full, q_pop, q_empty;
  sxfr_pkg::cmd_t q_wdata, q_rdata;
  sxfr_pkg::res_t res;

  sxfr_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .sync_byte_we    (sync_byte_we),
    .sync_byte_wdata (sync_byte_wdata),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .abort           (abort),
    .cmd_push        (q_push),
    .cmd             (q_wdata),
    .cmd_full        (q_full)
  );

  sxfr_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  sxfr_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (q_rdata),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign frame_status = res.frame_status;
  assign out_byte     = res.out_byte;
  assign is_last      = res.is_last;

endmodule

// ===== test/sync_length_xor_frame_receiver_core_test.sv =====
// Self-checking testbench for sync_length_xor_frame_receiver_core: random framed
// byte streams against a scoreboard that predicts payload replays and checksum errors.
// Depends on sxfr_pkg and the core RTL only.
module sync_length_xor_frame_receiver_core_test;

  localparam int PAYLOAD = sxfr_pkg::PAYLOAD_BYTES_DEF;
  localparam int CLK_HALF = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {HUNTING, IN_PAYLOAD, AT_CHECKSUM} rx_phase_e;
  typedef enum int {FRAME_GOOD, FRAME_BAD, FRAME_ABORTED} frame_kind_e;

  class frame_scoreboard;
    logic [7:0]     sync_byte;
    rx_phase_e      phase;
    int             taken;
    logic [7:0]     xor_acc;
    logic [7:0]     frame_data [PAYLOAD];
    sxfr_pkg::res_t expected_q [$];
    int             errors;
    int             results_seen;
    int             good_frames;
    int             bad_frames;
    int             aborts;

    function new();
      sync_byte = sxfr_pkg::SYNC_BYTE_RST;
      restart();
      errors = 0;
      results_seen = 0;
      good_frames = 0;
      bad_frames = 0;
      aborts = 0;
    endfunction

    function void restart();
      phase = HUNTING;
      taken = 0;
      xor_acc = 8'h00;
    endfunction

    // advance the predicted receiver state by one accepted input transfer
    function void note_byte(logic [7:0] b, logic ab);
      sxfr_pkg::res_t r;
      if (ab) begin
        aborts++;
        restart();
        return;
      end
      case (phase)
        IN_PAYLOAD: begin
          frame_data[taken] = b;
          xor_acc ^= b;
          taken++;
          if (taken >= PAYLOAD) phase = AT_CHECKSUM;
        end
        AT_CHECKSUM: begin
          if (b == xor_acc) begin
            good_frames++;
            for (int i = 0; i < PAYLOAD; i++) begin
              r.frame_status = 1'b0;
              r.out_byte = frame_data[i];
              r.is_last = (i == PAYLOAD - 1);
              expected_q.push_back(r);
            end
          end else begin
            bad_frames++;
            r.frame_status = 1'b1;
            r.out_byte = xor_acc;
            r.is_last = 1'b1;
            expected_q.push_back(r);
          end
          restart();
        end
        default: begin
          if (b == sync_byte) begin
            restart();
            phase = IN_PAYLOAD;
          end else begin
            phase = HUNTING;
          end
        end
      endcase
    endfunction

    function void check_result(logic fs, logic [7:0] ob, logic last);
      sxfr_pkg::res_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0b byte %h last %0b", $time, fs, ob, last);
        return;
      end
      e = expected_q.pop_front();
      if (fs !== e.frame_status) begin
        errors++;
        $display("%0t: frame_status expected %0b actual %0b", $time, e.frame_status, fs);
      end
      if (ob !== e.out_byte) begin
        errors++;
        $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, ob);
      end
      if (last !== e.is_last) begin
        errors++;
        $display("%0t: is_last expected %0b actual %0b", $time, e.is_last, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sync_byte_we = 1'b0;
  logic [7:0] sync_byte_wdata = 8'h00;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       abort = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       frame_status;
  logic [7:0] out_byte;
  logic       is_last;

  frame_scoreboard sb;
  int  items = 0;
  int  settings = 1;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  int  pop_wait = 0;
  int  rx_mode_left = 0;

  sync_length_xor_frame_receiver_core dut (
    .clk             (clk),
    .rst             (rst),
    .sync_byte_we    (sync_byte_we),
    .sync_byte_wdata (sync_byte_wdata),
    .push            (push),
    .full            (full),
    .rx_byte         (rx_byte),
    .abort           (abort),
    .empty           (empty),
    .pop             (pop),
    .frame_status    (frame_status),
    .out_byte        (out_byte),
    .is_last         (is_last)
  );

  always #CLK_HALF clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: check each transfer, then decide whether to stall
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_wait <= 0;
      rx_mode_left <= 0;
    end else begin
      if (pop && !empty) sb.check_result(frame_status, out_byte, is_last);
      if (rx_mode_left == 0) begin
        rx_steady <= ($urandom_range(0, 2) == 0);
        rx_mode_left <= $urandom_range(40, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait <= pop_wait - 1;
      end else begin
        pop <= 1'b1;
        if (!rx_steady && $urandom_range(0, 2) == 0) pop_wait <= pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ab);
    int gap;
    push <= 1'b1;
    rx_byte <= b;
    abort <= ab;
    do @(posedge clk); while (full);
    sb.note_byte(b, ab);
    items++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_sync(input logic [7:0] v);
    drain_results();
    // bytes that make no result may still sit in the command queue
    repeat (DRAIN_CYCLES) @(posedge clk);
    sync_byte_we <= 1'b1;
    sync_byte_wdata <= v;
    @(posedge clk);
    sync_byte_we <= 1'b0;
    sb.sync_byte = v;
    settings++;
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0] b;
    logic [7:0] sum;
    int cut;
    int r;
    sum = 8'h00;
    tx_steady = ($urandom_range(0, 3) == 0);
    // an abort may land anywhere from the first payload byte to the checksum slot
    cut = (kind == FRAME_ABORTED) ? $urandom_range(0, PAYLOAD) : PAYLOAD + 1;
    send_byte(sb.sync_byte, 1'b0);
    for (int i = 0; i <= PAYLOAD; i++) begin
      if (i == cut) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      if (i < PAYLOAD) begin
        r = $urandom_range(0, 15);
        if (r == 0) b = sb.sync_byte;
        else if (r == 1) b = 8'h00;
        else if (r == 2) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        sum ^= b;
        send_byte(b, 1'b0);
      end else if (kind == FRAME_BAD) begin
        send_byte(sum ^ 8'($urandom_range(1, 255)), 1'b0);
      end else begin
        send_byte(sum, 1'b0);
      end
    end
  endtask

  // line noise between frames; keeps clear of the sync byte
  task automatic send_noise();
    logic [7:0] b;
    int n;
    tx_steady = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == sb.sync_byte) b = ~b;
      send_byte(b, ($urandom_range(0, 4) == 0));
    end
  endtask

  task automatic run_random(input int target);
    int r;
    while (items < target) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_frame(FRAME_GOOD);
      else if (r < 70) send_frame(FRAME_BAD);
      else if (r < 82) send_frame(FRAME_ABORTED);
      else send_noise();
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, aborts in and out of a frame, sync byte as data
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(sxfr_pkg::SYNC_BYTE_RST, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(sxfr_pkg::SYNC_BYTE_RST, 1'b0);
    send_byte(sxfr_pkg::SYNC_BYTE_RST, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h00, 1'b1);

    send_frame(FRAME_GOOD);
    // sender holds off until the replay has fully drained
    drain_results();
    send_frame(FRAME_BAD);
    run_random(90);

    write_sync(8'h00);
    run_random(150);
    write_sync(8'hFF);
    run_random(210);
    write_sync(8'($urandom_range(1, 254)));
    run_random(270);

    drain_results();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;

    $display("%0d input transfers over %0d sync byte settings, %0d aborts",
             items, settings, sb.aborts);
    $display("%0d good frames, %0d checksum errors, %0d results checked",
             sb.good_frames, sb.bad_frames, sb.results_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("timeout with %0d results still expected", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sxfr_pkg.sv
rtl/core/sxfr_front.sv
rtl/core/sxfr_cmdq.sv
rtl/core/sxfr_back.sv
rtl/core/sync_length_xor_frame_receiver_core.sv
test/sync_length_xor_frame_receiver_core_test.sv
